// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_ALWAYS(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- src/sdst_pkg.sv -----
// ----------------------------------------------------------------------------
// SIP dialog state table package
// Request and result types, opcodes, event codes and dialog state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sdst_pkg;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_EVENT  = 2'd1;
	localparam logic [1:0] OP_REF    = 2'd2;
	localparam logic [1:0] OP_UNREF  = 2'd3;

	localparam logic [2:0] EV_TDEL   = 3'd0;
	localparam logic [2:0] EV_RPL1XX = 3'd1;
	localparam logic [2:0] EV_RPL3XX = 3'd2;
	localparam logic [2:0] EV_RPL2XX = 3'd3;
	localparam logic [2:0] EV_ACK    = 3'd4;
	localparam logic [2:0] EV_BYE    = 3'd5;
	localparam logic [2:0] EV_PRACK  = 3'd6;
	localparam logic [2:0] EV_OTHER  = 3'd7;

	localparam logic [2:0] ST_FREE      = 3'd0;
	localparam logic [2:0] ST_UNCONF    = 3'd1;
	localparam logic [2:0] ST_EARLY     = 3'd2;
	localparam logic [2:0] ST_CONF_NA   = 3'd3;
	localparam logic [2:0] ST_CONFIRMED = 3'd4;
	localparam logic [2:0] ST_DELETED   = 3'd5;

	typedef struct packed {
		logic [1:0] opcode;
		logic [9:0] dialog_slot;
		logic [2:0] event_code;
		logic [7:0] count_amount;
	} req_t;

	typedef struct packed {
		logic [2:0] state_before;
		logic [2:0] state_after;
		logic       drop_hash_ref;
		logic       bogus_event;
		logic       freed;
		logic [7:0] ref_now;
	} rsp_t;

endpackage

`default_nettype wire

// ----- src/sdst_mem.sv -----
// ----------------------------------------------------------------------------
// Slot memory
// Single write port, single read port, registered read (read-before-write).
// ----------------------------------------------------------------------------
`default_nettype none

module sdst_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/sdst_update.sv -----
// ----------------------------------------------------------------------------
// Dialog update logic
// Computes the next slot contents and the result for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module sdst_update #(
	parameter int REF_BITS = 8
) (
	input  wire sdst_pkg::req_t  req,
	input  wire logic            in_range,
	input  wire logic [2:0]      cur_state,
	input  wire logic            cur_bye,
	input  wire logic [REF_BITS-1:0] cur_ref,
	output logic      [2:0]      nxt_state,
	output logic                 nxt_bye,
	output logic [REF_BITS-1:0]  nxt_ref,
	output sdst_pkg::rsp_t       rsp
);

	import sdst_pkg::*;

	localparam int SW = ((REF_BITS > 8) ? REF_BITS : 8) + 1;
	localparam logic [SW-1:0] REF_MAX = SW'({REF_BITS{1'b1}});

	logic [SW-1:0]       add_base;
	logic [SW-1:0]       add_inc;
	logic [SW-1:0]       add_sum;
	logic [REF_BITS-1:0] add_sat;
	logic [SW-1:0]       drop_amt;
	logic                drop_all;
	logic [REF_BITS-1:0] drop_left;
	logic                early_like;
	logic                conf_like;
	logic                drop;
	logic                bogus;
	logic                freed;

	// One saturating adder serves create, ref and the 2xx revival of a deleted dialog.
	assign add_base = (req.opcode == OP_CREATE) ? '0 : SW'(cur_ref);
	assign add_inc  = (req.opcode == OP_CREATE) ? SW'(req.count_amount) + SW'(1) :
	                  (req.opcode == OP_REF)    ? SW'(req.count_amount) : SW'(1);
	assign add_sum  = add_base + add_inc;
	assign add_sat  = (add_sum > REF_MAX) ? {REF_BITS{1'b1}} : add_sum[REF_BITS-1:0];

	// Unref drops the requested amount, a transaction delete drops one.
	assign drop_amt  = (req.opcode == OP_UNREF) ? SW'(req.count_amount) : SW'(1);
	assign drop_all  = drop_amt >= SW'(cur_ref);
	assign drop_left = cur_ref - drop_amt[REF_BITS-1:0];

	assign early_like = cur_state inside {ST_UNCONF, ST_EARLY};
	assign conf_like  = cur_state inside {ST_CONF_NA, ST_CONFIRMED};

	always_comb begin
		nxt_state = cur_state;
		nxt_bye   = cur_bye;
		nxt_ref   = cur_ref;
		drop      = 1'b0;
		bogus     = 1'b0;
		freed     = 1'b0;
		if (!in_range) begin
			bogus = 1'b1;
		end else if (req.opcode == OP_CREATE) begin
			if (cur_state == ST_FREE) begin
				nxt_state = ST_UNCONF;
				nxt_bye   = 1'b0;
				nxt_ref   = add_sat;
			end else begin
				bogus = 1'b1;
			end
		end else if (cur_state == ST_FREE) begin
			bogus = 1'b1;
		end else begin
			case (req.opcode)
				OP_REF: begin
					nxt_ref = add_sat;
				end
				OP_UNREF: begin
					if (req.count_amount != 8'd0) begin
						if (drop_all) begin
							freed = 1'b1;
						end else begin
							nxt_ref = drop_left;
						end
					end
				end
				default: begin
					case (req.event_code)
						EV_TDEL: begin
							if (early_like || conf_like) begin
								if (early_like) begin
									nxt_state = ST_DELETED;
									drop      = 1'b1;
								end
								if (drop_all) begin
									freed = 1'b1;
								end else begin
									nxt_ref = drop_left;
								end
							end else if (cur_state == ST_DELETED) begin
								drop = 1'b1;
							end else begin
								bogus = 1'b1;
							end
						end
						EV_RPL1XX: begin
							if (early_like) nxt_state = ST_EARLY;
							else bogus = 1'b1;
						end
						EV_RPL3XX: begin
							if (early_like) begin
								nxt_state = ST_DELETED;
								drop      = 1'b1;
							end else begin
								bogus = 1'b1;
							end
						end
						EV_RPL2XX: begin
							if (cur_state == ST_DELETED) begin
								if (cur_bye) begin
									bogus = 1'b1;
								end else begin
									nxt_ref   = add_sat;
									nxt_state = ST_CONF_NA;
								end
							end else if (early_like) begin
								nxt_state = ST_CONF_NA;
							end else if (!conf_like) begin
								bogus = 1'b1;
							end
						end
						EV_ACK: begin
							if (cur_state == ST_CONF_NA) nxt_state = ST_CONFIRMED;
							else if (cur_state != ST_CONFIRMED && cur_state != ST_DELETED)
								bogus = 1'b1;
						end
						EV_BYE: begin
							if (conf_like) begin
								nxt_bye   = 1'b1;
								nxt_state = ST_DELETED;
								drop      = 1'b1;
							end else if (cur_state != ST_DELETED) begin
								bogus = 1'b1;
							end
						end
						EV_PRACK: begin
							if (cur_state != ST_EARLY && cur_state != ST_CONF_NA) bogus = 1'b1;
						end
						default: begin
							if (!conf_like) bogus = 1'b1;
						end
					endcase
				end
			endcase
		end
		// A count that reaches zero releases the slot whatever state it was headed for.
		if (freed) begin
			nxt_state = ST_FREE;
			nxt_bye   = 1'b0;
			nxt_ref   = '0;
		end
	end

	always_comb begin
		rsp = '0;
		rsp.bogus_event = bogus;
		if (in_range) begin
			rsp.state_before  = cur_state;
			rsp.state_after   = nxt_state;
			rsp.drop_hash_ref = drop;
			rsp.freed         = freed;
			rsp.ref_now       = 8'(nxt_ref);
		end
	end

endmodule

`default_nettype wire

// ----- src/sip_dialog_state_table.sv -----
// ----------------------------------------------------------------------------
// SIP dialog state table
// Dialog slot table with state, bye-seen flag and reference count per slot.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  request   start, busy            req  (sdst_pkg::req_t)
//  result    rsp_valid (strobe)     rsp  (sdst_pkg::rsp_t)
//
// One request per cycle is accepted while busy is low; its result strobe
// is registered from s1_valid_q and high for a single cycle. The slot memory is
// read at the accepting edge and written back in the next cycle; a one-entry
// forwarding register covers a request to the slot written in that same cycle.
// After reset a clearing pass writes every slot, with busy high throughout.
// The result receiver cannot stall, so busy depends only on the clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sip_dialog_state_table #(
	parameter int SLOTS    = 1024,
	parameter int REF_BITS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire sdst_pkg::req_t req,
	output logic          rsp_valid,
	output sdst_pkg::rsp_t rsp
);

	import sdst_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int WW = REF_BITS + 4;

	logic          accept;
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	logic          s1_valid_q;
	req_t          req_s1;
	logic [AW-1:0] addr_s1;
	logic          in_range_s1;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [WW-1:0] fwd_word_q;

	logic [WW-1:0] rd_word;
	logic [WW-1:0] cur_word;
	logic [WW-1:0] upd_word;
	logic          upd_we;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;

	logic [2:0]          nxt_state;
	logic                nxt_bye;
	logic [REF_BITS-1:0] nxt_ref;
	rsp_t                upd_rsp;

	assign busy   = clearing_q;
	assign accept = start && !busy;

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
			rsp_valid   <= 1'b0;
		end else begin
			s1_valid_q  <= accept;
			fwd_valid_q <= upd_we;
			rsp_valid   <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			addr_s1     <= AW'(req.dialog_slot);
			in_range_s1 <= 32'(req.dialog_slot) < SLOTS;
		end
		fwd_addr_q <= addr_s1;
		fwd_word_q <= upd_word;
		if (s1_valid_q) begin
			rsp <= upd_rsp;
		end
	end

	sdst_mem #(
		.DEPTH (SLOTS),
		.WIDTH (WW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (accept),
		.rd_addr (AW'(req.dialog_slot)),
		.rd_data (rd_word)
	);

	// The memory returns the old word when the previous request wrote the same slot.
	assign cur_word = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_word_q : rd_word;

	sdst_update #(
		.REF_BITS (REF_BITS)
	) u_update (
		.req       (req_s1),
		.in_range  (in_range_s1),
		.cur_state (cur_word[WW-2 -: 3]),
		.cur_bye   (cur_word[WW-1]),
		.cur_ref   (cur_word[REF_BITS-1:0]),
		.nxt_state (nxt_state),
		.nxt_bye   (nxt_bye),
		.nxt_ref   (nxt_ref),
		.rsp       (upd_rsp)
	);

	assign upd_word  = {nxt_bye, nxt_state, nxt_ref};
	assign upd_we    = s1_valid_q && in_range_s1;
	assign mem_we    = clearing_q || upd_we;
	assign mem_waddr = clearing_q ? clr_cnt_q : addr_s1;
	assign mem_wdata = clearing_q ? '0 : upd_word;

	`ASSERT_ALWAYS(a_result_follows, clk, arst_n, s1_valid_q |=> rsp_valid, "result strobe missing")
	`ASSERT_ALWAYS(a_range_bogus, clk, arst_n, (s1_valid_q && !in_range_s1) |=> (rsp.bogus_event && rsp.state_after == ST_FREE && rsp.ref_now == 8'd0), "out-of-range slot not reported")
	`ASSERT_ALWAYS(a_freed_clean, clk, arst_n, (rsp_valid && rsp.freed) |-> (rsp.state_after == ST_FREE && rsp.state_before != ST_FREE && rsp.ref_now == 8'd0), "freed slot not clean")
	`ASSERT_NEVER(a_no_write_clash, clk, arst_n, clearing_q && s1_valid_q, "request in flight during clearing pass")

endmodule

`default_nettype wire
